FILE: src/integer_bilinear_upscaler_assert.svh
// Assertion macros used by the back end of the upscaler.
`ifndef INTEGER_BILINEAR_UPSCALER_ASSERT_SVH
`define INTEGER_BILINEAR_UPSCALER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define IBU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define IBU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ibu_pkg.sv
// Types, constants and arithmetic helpers of the bilinear upscaler.
package ibu_pkg;

	localparam int DEF_MAX_SOURCE_WIDTH = 2048;
	localparam int DEF_MAX_SCALE = 8;
	localparam int HEIGHT_LIMIT = 2048;
	localparam int ROW_W = 11;
	localparam int COORD_W = 14;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CFG_SCALE = 2'd0;
	localparam logic [1:0] CFG_SOURCE_WIDTH = 2'd1;
	localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd2;

	localparam logic [3:0] SCALE_RESET = 4'd2;
	localparam logic [11:0] WIDTH_RESET = 12'd640;
	localparam logic [11:0] HEIGHT_RESET = 12'd480;

	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic last;
	} out_t;

	// One source pixel with its 2x2 neighborhood and the corner of its output block.
	typedef struct packed {
		rgb_t ul;
		rgb_t up;
		rgb_t left;
		rgb_t cur;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic c0;
		logic r0;
	} job_t;

	// Rounded-up 2^16/s, exact for quotients of magnitudes up to 255.
	function automatic logic [16:0] recip(input logic [3:0] s);
		logic [16:0] r;
		begin
			unique case (s)
				4'd2: r = 17'd32768;
				4'd3: r = 17'd21846;
				4'd4: r = 17'd16384;
				4'd5: r = 17'd13108;
				4'd6: r = 17'd10923;
				4'd7: r = 17'd9363;
				4'd8: r = 17'd8192;
				default: r = 17'd65536;
			endcase
			return r;
		end
	endfunction

	// Step (b-a)/s truncated toward zero, as sign and magnitude.
	function automatic logic [8:0] div_step(input logic [7:0] a, input logic [7:0] b,
			input logic [3:0] s);
		logic neg;
		logic [7:0] m;
		logic [24:0] p;
		begin
			neg = (b < a);
			m = neg ? 8'(a - b) : 8'(b - a);
			p = 25'(m) * 25'(recip(s));
			return {neg, p[23:16]};
		end
	endfunction

	// a + f * step; the result stays between the two end points.
	function automatic logic [7:0] apply_step(input logic [7:0] a, input logic [8:0] sq,
			input logic [2:0] f);
		logic [10:0] p;
		begin
			p = 11'(f) * 11'(sq[7:0]);
			return sq[8] ? 8'(11'(a) - p) : 8'(11'(a) + p);
		end
	endfunction

endpackage

FILE: src/ibu_queue.sv
// Short job queue between the front and the back of the upscaler.
module ibu_queue import ibu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t din,
	output logic full,
	input logic pop,
	output job_t dout,
	output logic valid
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && valid;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

FILE: src/ibu_front.sv
// Front of the upscaler: position counters, line store and neighborhood assembly.
module ibu_front import ibu_pkg::*; #(
	parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic [3:0] s,
	input logic [11:0] source_width,
	input logic [11:0] source_height,
	input logic push,
	input in_t pixel,
	output logic full,
	output job_t job,
	output logic job_push,
	input logic q_full
);

	localparam int CW = $clog2(MAX_SOURCE_WIDTH);
	localparam int WW = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int CMPW = (WW > 12) ? WW : 12;

	logic [23:0] mem [MAX_SOURCE_WIDTH];
	logic [CW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	rgb_t left_q;
	rgb_t ul_q;
	logic v_s1;
	rgb_t above_s1;
	rgb_t cur_s1;
	logic [COORD_W-1:0] x1_s1;
	logic [COORD_W-1:0] y1_s1;
	logic c0_s1;
	logic r0_s1;
	logic accept;
	logic move;
	rgb_t cur;
	logic [CMPW-1:0] w_raw;
	logic [CMPW-1:0] w_eff;
	logic [11:0] h_eff;

	assign cur = {pixel.red_in, pixel.green_in, pixel.blue_in};
	assign full = v_s1 && q_full;
	assign accept = push && !full;
	assign move = v_s1 && !q_full;
	assign job_push = v_s1;

	assign w_raw = CMPW'(source_width);
	assign w_eff = (w_raw == '0) ? CMPW'(1) :
		(w_raw > CMPW'(MAX_SOURCE_WIDTH)) ? CMPW'(MAX_SOURCE_WIDTH) : w_raw;
	assign h_eff = (source_height == '0) ? 12'd1 : source_height;

	assign job = '{ul: ul_q, up: above_s1, left: left_q, cur: cur_s1,
		x1: x1_s1, y1: y1_s1, c0: c0_s1, r0: r0_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
			ul_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
				if (CMPW'(col_q) + CMPW'(1) >= w_eff) begin
					col_q <= '0;
					row_q <= (12'(row_q) + 12'd1 >= h_eff) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (move) begin
				v_s1 <= 1'b0;
			end
			if (move) begin
				left_q <= cur_s1;
				ul_q <= above_s1;
			end
		end
	end

	// The read returns the entry as it was before this pixel overwrites it.
	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1 <= mem[col_q];
			mem[col_q] <= cur;
			cur_s1 <= cur;
			x1_s1 <= COORD_W'(col_q) * COORD_W'(s);
			y1_s1 <= COORD_W'(row_q) * COORD_W'(s);
			c0_s1 <= (col_q == '0);
			r0_s1 <= (row_q == '0);
		end
	end

endmodule

FILE: src/ibu_back.sv
// Back of the upscaler: output block sequencer and four-stage interpolation pipeline.
module ibu_back import ibu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [3:0] s,
	input job_t job,
	input logic job_valid,
	output logic job_pop,
	output out_t result,
	output logic empty,
	input logic pop
);

`include "integer_bilinear_upscaler_assert.svh"

	logic adv;
	logic issue;
	logic busy_q;
	logic [3:0] i_q;
	logic [3:0] j_q;
	logic [3:0] start_i;
	logic [3:0] start_j;
	logic [3:0] cur_i;
	logic [3:0] cur_j;
	logic is_lx;
	logic is_ly;
	logic [2:0] fx;
	logic [2:0] fy;
	logic [COORD_W-1:0] x;
	logic [COORD_W-1:0] y;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [7:0] at_s1 [3];
	logic [7:0] ab_s1 [3];
	logic [8:0] qt_s1 [3];
	logic [8:0] qb_s1 [3];
	logic [2:0] fx_s1, fy_s1, fy_s2, fy_s3;
	logic [COORD_W-1:0] x_s1, x_s2, x_s3, x_s4;
	logic [COORD_W-1:0] y_s1, y_s2, y_s3, y_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [7:0] top_s2 [3];
	logic [7:0] bot_s2 [3];
	logic [7:0] top_s3 [3];
	logic [8:0] qv_s3 [3];
	logic [7:0] v_s4d [3];

	assign adv = !v_s4 || pop;
	assign issue = job_valid && adv;

	assign start_i = job.c0 ? s : 4'd1;
	assign start_j = job.r0 ? s : 4'd1;
	assign cur_i = busy_q ? i_q : start_i;
	assign cur_j = busy_q ? j_q : start_j;
	assign is_lx = (cur_i == s);
	assign is_ly = (cur_j == s);
	assign fx = is_lx ? 3'd0 : cur_i[2:0];
	assign fy = is_ly ? 3'd0 : cur_j[2:0];
	assign x = job.x1 - COORD_W'(s) + COORD_W'(cur_i);
	assign y = job.y1 - COORD_W'(s) + COORD_W'(cur_j);
	assign job_pop = issue && is_lx && is_ly;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (issue) begin
				if (is_lx) begin
					if (is_ly) begin
						busy_q <= 1'b0;
					end else begin
						busy_q <= 1'b1;
						i_q <= start_i;
						j_q <= cur_j + 1'b1;
					end
				end else begin
					busy_q <= 1'b1;
					i_q <= cur_i + 1'b1;
					j_q <= cur_j;
				end
			end
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				// Upper row is the previous source row only inside the block.
				at_s1[k] <= (fx != '0) ? ((fy != '0) ? job.ul[k] : job.left[k]) :
					((fy != '0) ? job.up[k] : job.cur[k]);
				ab_s1[k] <= (fx != '0) ? job.left[k] : job.cur[k];
				qt_s1[k] <= div_step((fy != '0) ? job.ul[k] : job.left[k],
					(fy != '0) ? job.up[k] : job.cur[k], s);
				qb_s1[k] <= div_step(job.left[k], job.cur[k], s);
				top_s2[k] <= apply_step(at_s1[k], qt_s1[k], fx_s1);
				bot_s2[k] <= apply_step(ab_s1[k], qb_s1[k], fx_s1);
				top_s3[k] <= top_s2[k];
				qv_s3[k] <= div_step(top_s2[k], bot_s2[k], s);
				v_s4d[k] <= apply_step(top_s3[k], qv_s3[k], fy_s3);
			end
			fx_s1 <= fx;
			fy_s1 <= fy;
			x_s1 <= x;
			y_s1 <= y;
			last_s1 <= is_lx && is_ly;
			fy_s2 <= fy_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			last_s2 <= last_s1;
			fy_s3 <= fy_s2;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			last_s3 <= last_s2;
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			last_s4 <= last_s3;
		end
	end

	assign empty = !v_s4;
	assign result = '{out_x: x_s4, out_y: y_s4, red_out: v_s4d[2], green_out: v_s4d[1],
		blue_out: v_s4d[0], last: last_s4};

	`IBU_ASSERT_NOW(a_pop_on_last, job_pop, job_valid && cur_i == s && cur_j == s,
		"job released before its last output pixel")
	`IBU_ASSERT_NOW(a_frac_below_scale, v_s1, 4'(fx_s1) < s && 4'(fy_s1) < s,
		"fraction not below the scale")
	`IBU_ASSERT_NEXT(a_stall_holds, v_s4 && !pop, v_s4 && $stable(last_s4) && $stable(x_s4),
		"pending output pixel changed under stall")
	`IBU_ASSERT_NOW(a_no_issue_stalled, issue, !v_s4 || pop,
		"pixel issued into a stalled pipeline")

endmodule

FILE: src/integer_bilinear_upscaler.sv
// Top level of the integer-factor bilinear RGB upscaler.
// The block enlarges an RGB image by an integer factor s (register scale, 1..8).
// Source pixels come in raster order through a queue-like input: a request is
// taken at a rising edge with push high and full low. Each source pixel causes
// the output pixels whose bottom-right corner it is: s by s of them, s on the
// first row or column, one for the very first pixel. They leave block by block
// on a queue-like output, each block in raster order: the oldest one sits on
// result while empty is low and is taken at an edge with pop high; last marks the
// final output of a pixel. The first output of a pixel passes the front register,
// the job queue and the back pipeline stages. The back end emits one output pixel
// per cycle unless a pending output is left untaken; that output loop sets the
// throughput, and a two-entry job queue lets the front keep taking pixels meanwhile.
// When pop stays low the whole back pipeline holds; the queue then fills and
// full rises. Configuration writes (scale, source_width, source_height) use
// cfg_valid/cfg_ready and are always taken; write them only while idle.
// Reset restores scale 2, width 640, height 480 and clears position and
// neighbor registers; the line store needs no clearing pass.
module integer_bilinear_upscaler import ibu_pkg::*; #(
	parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
	parameter int MAX_SCALE = DEF_MAX_SCALE
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_t pixel,
	output logic empty,
	input logic pop,
	output out_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [11:0] cfg_data
);

	logic [3:0] scale_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [3:0] s_eff;
	job_t f_job;
	logic f_push;
	logic q_full;
	job_t b_job;
	logic b_valid;
	logic b_pop;

	// The register port never stalls a request.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCALE: scale_q <= cfg_data[3:0];
				CFG_SOURCE_WIDTH: width_q <= cfg_data;
				CFG_SOURCE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A scale of zero acts as one and anything above the limit acts as the limit.
	assign s_eff = (scale_q == '0) ? 4'd1 :
		(scale_q > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : scale_q;

	ibu_front #(
		.MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s(s_eff),
		.source_width(width_q),
		.source_height(height_q),
		.push(push),
		.pixel(pixel),
		.full(full),
		.job(f_job),
		.job_push(f_push),
		.q_full(q_full)
	);

	ibu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_push),
		.din(f_job),
		.full(q_full),
		.pop(b_pop),
		.dout(b_job),
		.valid(b_valid)
	);

	ibu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.s(s_eff),
		.job(b_job),
		.job_valid(b_valid),
		.job_pop(b_pop),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

endmodule
